// ===== design/integer_list_validator_assert.svh =====
// assertion macros shared by the integer list validator modules
// no dependencies; included inside module bodies after the package import
`ifndef INTEGER_LIST_VALIDATOR_ASSERT_SVH
`define INTEGER_LIST_VALIDATOR_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define ILV_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ilv assertion failed");
// next-cycle implication, disabled during reset
`define ILV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ilv assertion failed");
`else
`define ILV_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ILV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/ilv_pkg.sv =====
// types, codes and character helpers for the integer list validator
// no dependencies
`timescale 1ns / 1ps

package ilv_pkg;

  typedef enum logic [2:0] {
    ERR_NONE           = 3'd0,
    ERR_ILLEGAL_COMMA  = 3'd1,
    ERR_NON_DIGIT      = 3'd2,
    ERR_MISSING_COMMA  = 3'd3,
    ERR_TRAILING_COMMA = 3'd4,
    ERR_RANGE          = 3'd5
  } err_code_t;

  typedef enum logic [2:0] {
    CC_BLANK,
    CC_COMMA,
    CC_SIGN,
    CC_DIGIT,
    CC_OTHER
  } char_class_t;

  localparam int unsigned MagW = 10;
  localparam logic [MagW-1:0] MagMax = 10'd1023;
  localparam logic [MagW-1:0] RangeHigh = 10'd511;
  localparam logic [MagW-1:0] RangeLowMag = 10'd512;

  typedef struct packed {
    logic [7:0] character;
    logic       end_marker;
  } in_item_t;

  typedef struct packed {
    logic      list_valid;
    err_code_t error_code;
  } verdict_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t cls;
    if (c == 8'h20 || c == 8'h09 || c == 8'h0a) begin
      cls = CC_BLANK;
    end else if (c == 8'h2c) begin
      cls = CC_COMMA;
    end else if (c == 8'h2b || c == 8'h2d) begin
      cls = CC_SIGN;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = CC_DIGIT;
    end else begin
      cls = CC_OTHER;
    end
    return cls;
  endfunction

  function automatic logic over_range(input logic neg, input logic [MagW-1:0] mag);
    return neg ? (mag > RangeLowMag) : (mag > RangeHigh);
  endfunction

endpackage

// ===== design/ilv_if.sv =====
// valid/ready channel interfaces for the character input and the verdict output
// depends on ilv_pkg for the error code type
`timescale 1ns / 1ps

interface ilv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_marker;

  modport source (output valid, output character, output end_marker, input ready);
  modport sink (input valid, input character, input end_marker, output ready);
endinterface

interface ilv_out_if;
  logic               valid;
  logic               ready;
  logic               list_valid;
  ilv_pkg::err_code_t error_code;

  modport source (output valid, output list_valid, output error_code, input ready);
  modport sink (input valid, input list_valid, input error_code, output ready);
endinterface

// ===== design/ilv_in_stage.sv =====
// input register: captures one character transaction per cycle while it is empty or being popped
// depends on ilv_pkg and ilv_in_if
`timescale 1ns / 1ps

module ilv_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  ilv_in_if.sink            in_ch,
  input  logic              pop_i,
  output logic              item_valid_o,
  output ilv_pkg::in_item_t item_o
);
  import ilv_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ch.ready = !valid_r || pop_i;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ch.ready) begin
      valid_nxt = in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.character  <= in_ch.character;
      item_r.end_marker <= in_ch.end_marker;
    end
  end

  assign item_valid_o = valid_r;
  assign item_o       = item_r;

endmodule

// ===== design/ilv_parser.sv =====
// per-character syntax and range tracking; emits a verdict on the end marker
// depends on ilv_pkg and the assertion macro header
`timescale 1ns / 1ps

module ilv_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take_i,
  input  ilv_pkg::in_item_t item_i,
  output logic              verdict_valid_o,
  output ilv_pkg::verdict_t verdict_o
);
  import ilv_pkg::*;
  `include "integer_list_validator_assert.svh"

  logic            comma_seen_r, comma_seen_nxt;
  logic            blank_seen_r, blank_seen_nxt;
  logic            sign_pending_r, sign_pending_nxt;
  logic            sign_lacks_comma_r, sign_lacks_comma_nxt;
  err_code_t       first_error_r, first_error_nxt;
  logic            in_token_r, in_token_nxt;
  logic            token_stopped_r, token_stopped_nxt;
  logic            token_negative_r, token_negative_nxt;
  logic [MagW-1:0] token_magnitude_r, token_magnitude_nxt;
  logic            range_failed_r, range_failed_nxt;

  char_class_t     cls;
  logic [3:0]      digit;
  logic [13:0]     accum;
  logic            blocked;
  logic            closing_bad;
  err_code_t       code;

  assign cls         = classify(item_i.character);
  assign digit       = item_i.character[3:0];
  // magnitude * 10 + digit
  assign accum       = {1'b0, token_magnitude_r, 3'b000} + {3'b000, token_magnitude_r, 1'b0}
                     + {10'd0, digit};
  assign closing_bad = in_token_r && over_range(token_negative_r, token_magnitude_r);

  always_comb begin
    comma_seen_nxt       = comma_seen_r;
    blank_seen_nxt       = blank_seen_r;
    sign_pending_nxt     = sign_pending_r;
    sign_lacks_comma_nxt = sign_lacks_comma_r;
    first_error_nxt      = first_error_r;
    in_token_nxt         = in_token_r;
    token_stopped_nxt    = token_stopped_r;
    token_negative_nxt   = token_negative_r;
    token_magnitude_nxt  = token_magnitude_r;
    range_failed_nxt     = range_failed_r;
    blocked              = 1'b0;
    code                 = first_error_r;

    if (take_i && item_i.end_marker) begin
      if (first_error_r == ERR_NONE) begin
        priority if (sign_pending_r) begin
          code = ERR_NON_DIGIT;
        end else if (comma_seen_r) begin
          code = ERR_TRAILING_COMMA;
        end else if (range_failed_r || closing_bad) begin
          code = ERR_RANGE;
        end else begin
          code = ERR_NONE;
        end
      end
      // back to the empty-list state for the next transaction
      comma_seen_nxt       = 1'b1;
      blank_seen_nxt       = 1'b0;
      sign_pending_nxt     = 1'b0;
      sign_lacks_comma_nxt = 1'b0;
      first_error_nxt      = ERR_NONE;
      in_token_nxt         = 1'b0;
      token_stopped_nxt    = 1'b0;
      token_negative_nxt   = 1'b0;
      token_magnitude_nxt  = '0;
      range_failed_nxt     = 1'b0;
    end else if (take_i && first_error_r == ERR_NONE) begin
      // a pending sign is resolved by the character that follows it
      if (sign_pending_r) begin
        priority if (cls != CC_DIGIT) begin
          first_error_nxt = ERR_NON_DIGIT;
          blocked         = 1'b1;
        end else if (sign_lacks_comma_r) begin
          first_error_nxt = ERR_MISSING_COMMA;
          blocked         = 1'b1;
        end else begin
          sign_pending_nxt     = 1'b0;
          sign_lacks_comma_nxt = 1'b0;
        end
      end
      if (!blocked) begin
        unique case (cls)
          CC_BLANK: begin
            if (closing_bad) range_failed_nxt = 1'b1;
            in_token_nxt   = 1'b0;
            blank_seen_nxt = 1'b1;
          end
          CC_COMMA: begin
            if (comma_seen_r) begin
              first_error_nxt = ERR_ILLEGAL_COMMA;
            end else begin
              comma_seen_nxt = 1'b1;
              if (closing_bad) range_failed_nxt = 1'b1;
              in_token_nxt = 1'b0;
            end
          end
          CC_SIGN: begin
            sign_pending_nxt     = 1'b1;
            sign_lacks_comma_nxt = blank_seen_r && !comma_seen_r;
            comma_seen_nxt       = 1'b0;
            blank_seen_nxt       = 1'b0;
            if (!in_token_r) begin
              in_token_nxt        = 1'b1;
              token_stopped_nxt   = 1'b0;
              token_negative_nxt  = (item_i.character == 8'h2d);
              token_magnitude_nxt = '0;
            end else begin
              token_stopped_nxt = 1'b1;
            end
          end
          CC_DIGIT: begin
            if (blank_seen_r && !comma_seen_r) begin
              first_error_nxt = ERR_MISSING_COMMA;
            end else begin
              comma_seen_nxt = 1'b0;
              blank_seen_nxt = 1'b0;
              if (!in_token_r) begin
                in_token_nxt        = 1'b1;
                token_stopped_nxt   = 1'b0;
                token_negative_nxt  = 1'b0;
                token_magnitude_nxt = {6'd0, digit};
              end else if (!token_stopped_r) begin
                token_magnitude_nxt = (accum > {4'd0, MagMax}) ? MagMax : accum[MagW-1:0];
              end
            end
          end
          default: begin
            first_error_nxt = ERR_NON_DIGIT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comma_seen_r       <= 1'b1;
      blank_seen_r       <= 1'b0;
      sign_pending_r     <= 1'b0;
      sign_lacks_comma_r <= 1'b0;
      first_error_r      <= ERR_NONE;
      in_token_r         <= 1'b0;
      token_stopped_r    <= 1'b0;
      token_negative_r   <= 1'b0;
      token_magnitude_r  <= '0;
      range_failed_r     <= 1'b0;
    end else begin
      comma_seen_r       <= comma_seen_nxt;
      blank_seen_r       <= blank_seen_nxt;
      sign_pending_r     <= sign_pending_nxt;
      sign_lacks_comma_r <= sign_lacks_comma_nxt;
      first_error_r      <= first_error_nxt;
      in_token_r         <= in_token_nxt;
      token_stopped_r    <= token_stopped_nxt;
      token_negative_r   <= token_negative_nxt;
      token_magnitude_r  <= token_magnitude_nxt;
      range_failed_r     <= range_failed_nxt;
    end
  end

  assign verdict_valid_o      = take_i && item_i.end_marker;
  assign verdict_o.list_valid = (code == ERR_NONE);
  assign verdict_o.error_code = code;

  // a verdict always leaves the tracker in its empty-list state
  `ILV_ASSERT_NEXT(a_reset_after_verdict, clk, rst_n, verdict_valid_o,
                   comma_seen_r && !in_token_r && first_error_r == ERR_NONE)
  // the first error sticks until the end marker
  `ILV_ASSERT_NEXT(a_error_sticky, clk, rst_n,
                   first_error_r != ERR_NONE && !verdict_valid_o, $stable(first_error_r))
  // the magnitude never leaves its saturated range
  `ILV_ASSERT_NOW(a_mag_sat, clk, rst_n, in_token_r, token_magnitude_r <= MagMax)

endmodule

// ===== design/ilv_out_stage.sv =====
// output register holding one verdict until the receiver takes it
// depends on ilv_pkg, ilv_out_if and the assertion macro header
`timescale 1ns / 1ps

module ilv_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_i,
  input  ilv_pkg::verdict_t verdict_i,
  output logic              free_o,
  ilv_out_if.source         out_ch
);
  import ilv_pkg::*;
  `include "integer_list_validator_assert.svh"

  logic     valid_r;
  logic     valid_nxt;
  verdict_t verdict_r;

  assign free_o = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (free_o) begin
      valid_nxt = load_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i && free_o) begin
      verdict_r <= verdict_i;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.list_valid = verdict_r.list_valid;
  assign out_ch.error_code = verdict_r.error_code;

  // the upstream never loads a verdict over one still waiting
  `ILV_ASSERT_NOW(a_no_overwrite, clk, rst_n, load_i, free_o)

endmodule

// ===== design/integer_list_validator.sv =====
// Integer list validator, top level.
// Depends on ilv_pkg, ilv_if, ilv_in_stage, ilv_parser and ilv_out_stage.
//
// Usage:
//   in_ch carries one character per transaction; a transaction with
//   end_marker set closes the list and carries no character.
//   out_ch carries one verdict per list: list_valid and error_code
//   (0 none, 1 illegal comma, 2 non-digit, 3 missing comma,
//   4 trailing comma, 5 out of range). Characters give no output.
// Timing:
//   one transaction per cycle is accepted, unless an end marker waits for
//   the output register; the parser logic tracks each character
//   combinationally from the input register. A verdict passes through the
//   input register and then the output register before it shows on out_ch.
// Reset:
//   rst_n low clears both channel registers and returns the parser to the
//   empty-list state. After each verdict the parser returns there too.
// Stall:
//   while out_ch.ready is low a waiting verdict holds; characters keep
//   flowing, and only a second end marker waits in the input register.
`timescale 1ns / 1ps

module integer_list_validator (
  input  logic      clk,
  input  logic      rst_n,
  ilv_in_if.sink    in_ch,
  ilv_out_if.source out_ch
);
  import ilv_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     out_free;
  logic     take;
  logic     verdict_valid;
  verdict_t verdict;

  // an end marker moves on only when the output register can take its verdict
  assign take = item_valid && (!item.end_marker || out_free);

  ilv_in_stage u_in_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .pop_i        (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ilv_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .take_i          (take),
    .item_i          (item),
    .verdict_valid_o (verdict_valid),
    .verdict_o       (verdict)
  );

  ilv_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (verdict_valid),
    .verdict_i (verdict),
    .free_o    (out_free),
    .out_ch    (out_ch)
  );

endmodule
